[rtl/mcc_pkg.sv]
`default_nettype none

package mcc_pkg;

  // Field widths fixed by the transaction format
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned DIST_W = 32;
  localparam int unsigned KEEP_W = 11;

  // Stored entry holds {train, query}
  localparam int unsigned ENTRY_W = 2 * IDX_W;

  localparam int unsigned MAX_REVERSE_ENTRIES_DEF = 1024;

  localparam logic [KEEP_W-1:0] KEEP_SAT = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Status from the scan engine to the controller
  typedef struct packed {
    logic busy;
    logic done;
  } scan_stat_t;

endpackage

`default_nettype wire

[rtl/mcc_ram.sv]
`default_nettype none

module mcc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/mcc_scan.sv]
`default_nettype none

module mcc_scan #(
  parameter int unsigned MAX_REVERSE_ENTRIES = mcc_pkg::MAX_REVERSE_ENTRIES_DEF,
  localparam int unsigned AW = $clog2(MAX_REVERSE_ENTRIES),
  localparam int unsigned CW = $clog2(MAX_REVERSE_ENTRIES + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [CW-1:0]                   entry_count,
  input  wire logic [mcc_pkg::IDX_W-1:0]       key_query,
  input  wire logic [mcc_pkg::IDX_W-1:0]       key_train,
  output logic                                 rd_en,
  output logic      [AW-1:0]                   rd_addr,
  input  wire logic [mcc_pkg::ENTRY_W-1:0]     rd_data,
  output mcc_pkg::scan_stat_t                  stat,
  output logic      [mcc_pkg::KEEP_W-1:0]      hits
);

  logic [CW-1:0] issue_cnt;
  logic          active;
  logic          pend;
  logic          issuing;
  logic          match;

  assign issuing = active && (issue_cnt < entry_count);
  assign rd_en   = issuing;
  assign rd_addr = issue_cnt[AW-1:0];

  // Stored entry is {train, query}: mutual when its train equals our query and vice versa
  assign match = (rd_data[mcc_pkg::ENTRY_W-1:mcc_pkg::IDX_W] == key_query) &&
                 (rd_data[mcc_pkg::IDX_W-1:0] == key_train);

  assign stat.busy = active;
  assign stat.done = active && !issuing && !pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pend   <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
      pend   <= 1'b0;
    end else begin
      pend <= issuing;
      if (stat.done) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      issue_cnt <= '0;
      hits      <= '0;
    end else begin
      if (issuing) begin
        issue_cnt <= issue_cnt + CW'(1);
      end
      if (pend && match && (hits != mcc_pkg::KEEP_SAT)) begin
        hits <= hits + mcc_pkg::KEEP_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/match_cross_check.sv]
// Clear and append transactions do not leave the idle state; the next one can be taken right after.
// A check raises result valid once the scan has read all N stored reverse entries, one entry
// per cycle through the single RAM read port (none on an empty table).
// Input is held off until the result is registered, longer while an earlier result waits there.
// Reset (rst, synchronous, active high) empties the table and clears the overflow flag;
// table contents are not cleared and entries beyond the fill count are never read.
`default_nettype none

module match_cross_check #(
  parameter int unsigned MAX_REVERSE_ENTRIES = mcc_pkg::MAX_REVERSE_ENTRIES_DEF,
  localparam int unsigned AW = $clog2(MAX_REVERSE_ENTRIES),
  localparam int unsigned CW = $clog2(MAX_REVERSE_ENTRIES + 1)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_axis_tdata: query_index[11:0], train_index[23:12], distance_bits[55:24]
  input  wire logic [55:0] s_axis_tdata,
  // s_axis_tuser: command[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // m_axis_tdata: kept_query_index[11:0], kept_train_index[23:12],
  //               kept_distance_bits[55:24], keep_count[66:56], zero pad[71:67]
  output logic      [71:0] m_axis_tdata,
  // m_axis_tuser: table_overflow[0]
  output logic      [0:0]  m_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  // Incoming transaction fields
  mcc_pkg::cmd_t                   in_cmd;
  logic [mcc_pkg::IDX_W-1:0]       in_query;
  logic [mcc_pkg::IDX_W-1:0]       in_train;
  logic [mcc_pkg::DIST_W-1:0]      in_dist;
  logic                            in_fire;
  logic                            out_free;

  assign in_cmd   = mcc_pkg::cmd_t'(s_axis_tuser);
  assign in_query = s_axis_tdata[11:0];
  assign in_train = s_axis_tdata[23:12];
  assign in_dist  = s_axis_tdata[55:24];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Table fill state
  logic [CW-1:0] tbl_count;
  logic          ovf;
  logic          tbl_full;
  logic          do_append;
  logic          do_check;

  assign tbl_full  = (tbl_count == CW'(MAX_REVERSE_ENTRIES));
  assign do_append = in_fire && (in_cmd == mcc_pkg::CMD_APPEND) && !tbl_full;
  assign do_check  = in_fire && (in_cmd == mcc_pkg::CMD_CHECK);

  // Held check transaction
  logic [mcc_pkg::IDX_W-1:0]  chk_query;
  logic [mcc_pkg::IDX_W-1:0]  chk_train;
  logic [mcc_pkg::DIST_W-1:0] chk_dist;
  logic                       chk_ovf;
  logic [mcc_pkg::KEEP_W-1:0] chk_hits;

  // Scan engine and RAM hookup
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [mcc_pkg::ENTRY_W-1:0]  rd_data;
  mcc_pkg::scan_stat_t          scan_stat;
  logic [mcc_pkg::KEEP_W-1:0]   scan_hits;

  mcc_ram #(
    .WIDTH (mcc_pkg::ENTRY_W),
    .DEPTH (MAX_REVERSE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (do_append),
    .wr_addr (tbl_count[AW-1:0]),
    .wr_data ({in_train, in_query}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mcc_scan #(
    .MAX_REVERSE_ENTRIES (MAX_REVERSE_ENTRIES)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (do_check),
    .entry_count (tbl_count),
    .key_query   (in_fire ? in_query : chk_query),
    .key_train   (in_fire ? in_train : chk_train),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .stat        (scan_stat),
    .hits        (scan_hits)
  );

  // Sequence: idle -> scan the table -> hand the result to the output register
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (do_check) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fill count and sticky overflow; clear drops both, append to a full table sets overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_count <= '0;
      ovf       <= 1'b0;
    end else if (in_fire) begin
      case (in_cmd)
        mcc_pkg::CMD_CLEAR: begin
          tbl_count <= '0;
          ovf       <= 1'b0;
        end
        mcc_pkg::CMD_APPEND: begin
          if (tbl_full) begin
            ovf <= 1'b1;
          end else begin
            tbl_count <= tbl_count + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the checked match for the whole scan and capture the hit count when the scan is done
  always_ff @(posedge clk) begin
    if (do_check) begin
      chk_query <= in_query;
      chk_train <= in_train;
      chk_dist  <= in_dist;
      chk_ovf   <= ovf;
    end
    if ((state == ST_SCAN) && scan_stat.done) begin
      chk_hits <= scan_hits;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      m_axis_tdata <= {5'd0, chk_hits, chk_dist, chk_train, chk_query};
      m_axis_tuser <= chk_ovf;
    end
  end

  // The fill count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    tbl_count <= CW'(MAX_REVERSE_ENTRIES))
    else $error("table fill count beyond depth");

  // A scan completes only while the controller waits on it
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_stat.done |-> (state == ST_SCAN))
    else $error("scan done outside of scan state");

  // A new result appears only out of the finish step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_FINISH))
    else $error("result valid without a finished scan");

  // Append to a full table raises the sticky overflow
  a_overflow_set: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (in_cmd == mcc_pkg::CMD_APPEND) && tbl_full) |=> ovf)
    else $error("overflow not set on dropped append");

  // The table cannot be read while a transaction is taken
  a_no_read_on_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> !rd_en)
    else $error("table read during accepted transaction");

endmodule

`default_nettype wire

[verif/mcc_checker.sv]
`timescale 1ns / 100ps

module mcc_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic [55:0]  s_axis_tdata,
  input wire logic [1:0]   s_axis_tuser,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [71:0]  m_axis_tdata,
  input wire logic [0:0]   m_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  output int unsigned      fail_count,
  output int unsigned      pending
);

  import mcc_pkg::*;

  localparam int unsigned DEPTH = MAX_REVERSE_ENTRIES_DEF;

  typedef struct packed {
    logic [IDX_W-1:0]  query;
    logic [IDX_W-1:0]  train;
    logic [DIST_W-1:0] distance;
    logic [KEEP_W-1:0] keep;
    logic              overflow;
  } kept_match_t;

  logic [IDX_W-1:0] rev_query [DEPTH];
  logic [IDX_W-1:0] rev_train [DEPTH];
  int unsigned      rev_fill;
  logic             rev_overflow;
  kept_match_t      expected_matches [$];
  int unsigned      err_total;

  initial begin
    fail_count = 0;
    pending    = 0;
    err_total  = 0;
    rev_fill   = 0;
    rev_overflow = 1'b0;
  end

  // count reverse entries that point back at this forward match
  function automatic kept_match_t predict_kept_match(input logic [IDX_W-1:0] q,
                                                     input logic [IDX_W-1:0] t,
                                                     input logic [DIST_W-1:0] d);
    kept_match_t r;
    int unsigned hits;
    hits = 0;
    for (int unsigned k = 0; k < rev_fill; k++) begin
      if (rev_train[k] == q && rev_query[k] == t && hits < KEEP_SAT) hits++;
    end
    r.query    = q;
    r.train    = t;
    r.distance = d;
    r.keep     = KEEP_W'(hits);
    r.overflow = rev_overflow;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_total < 40) $display("ERROR @%0t: %s", $realtime, msg);
    err_total++;
  endtask

  always @(posedge clk) begin
    kept_match_t want;
    kept_match_t fresh;
    cmd_t        cmd;
    if (rst) begin
      rev_fill     = 0;
      rev_overflow = 1'b0;
      expected_matches.delete();
    end else begin
      // compare before taking new input so a stray result is never paired
      // with a check accepted in the same cycle
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_matches.size() == 0) begin
          report_mismatch($sformatf("unexpected result q=%0d t=%0d keep=%0d",
                                    m_axis_tdata[11:0], m_axis_tdata[23:12],
                                    m_axis_tdata[66:56]));
        end else begin
          want = expected_matches.pop_front();
          if (m_axis_tdata[11:0] !== want.query)
            report_mismatch($sformatf("kept_query_index got %0d want %0d",
                                      m_axis_tdata[11:0], want.query));
          if (m_axis_tdata[23:12] !== want.train)
            report_mismatch($sformatf("kept_train_index got %0d want %0d",
                                      m_axis_tdata[23:12], want.train));
          if (m_axis_tdata[55:24] !== want.distance)
            report_mismatch($sformatf("kept_distance_bits got %h want %h",
                                      m_axis_tdata[55:24], want.distance));
          if (m_axis_tdata[66:56] !== want.keep)
            report_mismatch($sformatf("keep_count got %0d want %0d (q=%0d t=%0d)",
                                      m_axis_tdata[66:56], want.keep,
                                      want.query, want.train));
          if (m_axis_tuser[0] !== want.overflow)
            report_mismatch($sformatf("table_overflow got %b want %b",
                                      m_axis_tuser[0], want.overflow));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cmd = cmd_t'(s_axis_tuser);
        case (cmd)
          CMD_CLEAR: begin
            rev_fill     = 0;
            rev_overflow = 1'b0;
          end
          CMD_APPEND: begin
            if (rev_fill < DEPTH) begin
              rev_query[rev_fill] = s_axis_tdata[11:0];
              rev_train[rev_fill] = s_axis_tdata[23:12];
              rev_fill++;
            end else begin
              rev_overflow = 1'b1;
            end
          end
          CMD_CHECK: begin
            fresh = predict_kept_match(s_axis_tdata[11:0], s_axis_tdata[23:12],
                                       s_axis_tdata[55:24]);
            expected_matches = {expected_matches, fresh};
          end
          default: ;
        endcase
      end
    end
    pending    <= expected_matches.size();
    fail_count <= err_total;
  end

endmodule

[verif/tb_match_cross_check.sv]
`timescale 1ns / 100ps

module tb_match_cross_check;

  import mcc_pkg::*;

  localparam int unsigned TABLE_DEPTH   = MAX_REVERSE_ENTRIES_DEF;
  localparam int unsigned RANDOM_ITEMS  = 580;
  // sized for ~600 random items at full stall plus a full table phase
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned HOLD_AFTER    = 30;
  localparam int unsigned DRAIN_SETTLE  = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = CMD_NONE;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned cycle_count = 0;

  // stimulus-side bookkeeping, only used to shape the traffic
  int unsigned random_items = 0;
  int unsigned table_fill = 0;
  logic [23:0] stored_pairs [$];   // {train, query} of appended entries
  bit          quiet = 1'b0;       // no gaps on the sending side

  // receiver state
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  bit          hold_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  match_cross_check uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  mcc_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .fail_count    (fail_count),
    .pending       (pending_results)
  );

  // Mostly no gap, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Narrow pools flip only the low two bits of a random base, so repeats
  // and mutual hits are common while every index bit still toggles.
  function automatic logic [IDX_W-1:0] pick_index(input bit narrow,
                                                  input logic [IDX_W-1:0] base);
    if (narrow) return base ^ IDX_W'($urandom_range(0, 3));
    return IDX_W'($urandom);
  endfunction

  // Timeout: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: one long hold-off after HOLD_AFTER results so the block backs up
  // into its input, random stalls otherwise, and a stall-free window that recurs.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) results_seen++;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (cycle_count % 512 < 128) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        m_axis_tready <= (stall_left == 0);
      end
    end
  end

  // Offer one transaction and hold it until accepted, then maybe drop valid
  // for a random gap. Valid is left high when no gap follows.
  task automatic send_item(input cmd_t cmd, input logic [IDX_W-1:0] q,
                           input logic [IDX_W-1:0] t, input logic [DIST_W-1:0] d);
    int unsigned gap;
    logic [23:0] entry;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {d, t, q};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    case (cmd)
      CMD_CLEAR: begin
        table_fill = 0;
        stored_pairs.delete();
      end
      CMD_APPEND: begin
        if (table_fill < TABLE_DEPTH) begin
          entry = {t, q};
          stored_pairs = {stored_pairs, entry};
          table_fill++;
        end
      end
      default: ;
    endcase
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every expected result has come back.
  // The extra edge lets the checker's count catch up with the last
  // accepted transaction.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Index extremes, repeated and crossed entries, ignored commands,
  // a check on an empty table and a check after a clear.
  task automatic run_directed();
    send_item(CMD_CLEAR, 12'd0, 12'd0, 32'h0);
    send_item(CMD_CHECK, 12'd0, 12'd0, 32'h0);
    send_item(CMD_APPEND, 12'd0, 12'd0, $urandom);
    send_item(CMD_APPEND, 12'd4095, 12'd4095, $urandom);
    send_item(CMD_APPEND, 12'd4095, 12'd0, 32'hFFFF_FFFF);
    send_item(CMD_APPEND, 12'd4095, 12'd0, 32'h0);
    send_item(CMD_APPEND, 12'd0, 12'd4095, $urandom);
    // unused command carrying a matching pair: must neither store nor answer
    send_item(CMD_NONE, 12'd0, 12'd0, 32'hFFFF_FFFF);
    send_item(CMD_CHECK, 12'd0, 12'd0, 32'hFFFF_FFFF);
    send_item(CMD_CHECK, 12'd0, 12'd4095, 32'h0);
    send_item(CMD_CHECK, 12'd4095, 12'd0, 32'h8000_0001);
    send_item(CMD_CHECK, 12'd4095, 12'd4095, 32'h7FFF_FFFE);
    send_item(CMD_CHECK, 12'd123, 12'd456, $urandom);
    send_item(CMD_CLEAR, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
    send_item(CMD_CHECK, 12'd0, 12'd0, $urandom);
    send_item(CMD_NONE, 12'd4095, 12'd4095, 32'h0);
    send_item(CMD_CHECK, 12'd4095, 12'd4095, $urandom);
    wait_for_drain();
  endtask

  // Fill the table with one pair so a mirrored check counts every entry,
  // push past the end to raise the overflow flag, then clear it again.
  task automatic run_table_full();
    logic [IDX_W-1:0] fq;
    logic [IDX_W-1:0] ft;
    fq = 12'h5A5;
    ft = 12'hA5A;
    send_item(CMD_CLEAR, IDX_W'($urandom), IDX_W'($urandom), $urandom);
    repeat (TABLE_DEPTH) send_item(CMD_APPEND, fq, ft, $urandom);
    send_item(CMD_CHECK, ft, fq, $urandom);
    repeat (3) send_item(CMD_APPEND, ft, fq, $urandom);   // dropped
    send_item(CMD_CHECK, ft, fq, $urandom);
    send_item(CMD_CHECK, fq, ft, $urandom);
    send_item(CMD_NONE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
    send_item(CMD_APPEND, IDX_W'($urandom), IDX_W'($urandom), $urandom);  // dropped
    send_item(CMD_CHECK, ft, fq, 32'hFFFF_FFFF);
    send_item(CMD_CLEAR, IDX_W'($urandom), IDX_W'($urandom), $urandom);
    send_item(CMD_CHECK, ft, fq, 32'h0);
    wait_for_drain();
  endtask

  // One sequence: maybe clear, a few appends, then checks that mostly
  // mirror stored entries. Appends without checks, checks on an empty
  // table and stray unused commands give the broken cases.
  task automatic run_random_sequence();
    bit               narrow;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] q;
    logic [IDX_W-1:0] t;
    logic [23:0]      pair;
    int unsigned      n_app;
    int unsigned      n_chk;
    quiet  = ($urandom_range(0, 3) == 0);
    narrow = ($urandom_range(0, 2) != 0);
    base   = IDX_W'($urandom);
    // keep the table short so checks stay fast
    if (table_fill > 48 || $urandom_range(0, 99) < 35) begin
      send_item(CMD_CLEAR, IDX_W'($urandom), IDX_W'($urandom), $urandom);
      random_items++;
    end
    n_app = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 6);
    for (int unsigned i = 0; i < n_app; i++) begin
      if ($urandom_range(0, 11) == 0)
        send_item(CMD_NONE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
      send_item(CMD_APPEND, pick_index(narrow, base), pick_index(narrow, base), $urandom);
      random_items++;
    end
    n_chk = $urandom_range(0, 5);
    for (int unsigned i = 0; i < n_chk; i++) begin
      if (stored_pairs.size() != 0 && $urandom_range(0, 99) < 65) begin
        pair = stored_pairs[$urandom_range(0, stored_pairs.size() - 1)];
        q = pair[23:12];
        t = pair[11:0];
      end else begin
        q = pick_index(narrow, base);
        t = pick_index(narrow, base);
      end
      if ($urandom_range(0, 11) == 0) send_item(CMD_NONE, q, t, $urandom);
      send_item(CMD_CHECK, q, t, $urandom);
      random_items++;
    end
    if ($urandom_range(0, 7) == 0) wait_for_drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_table_full();
    while (random_items < RANDOM_ITEMS) run_random_sequence();

    wait_for_drain();
    // let any stray result show up before the verdict
    repeat (DRAIN_SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mcc_pkg.sv
rtl/mcc_ram.sv
rtl/mcc_scan.sv
rtl/match_cross_check.sv
verif/mcc_checker.sv
verif/tb_match_cross_check.sv
